>>> design/ckp_pkg.sv
// shared types, constants and step functions for the chroma key pipeline
// no dependencies; imported by every module of the block
package ckp_pkg;

    // pipeline shape
    localparam int CHR_STAGES   = 3;
    localparam int SQ_STAGES    = 5;
    localparam int SQ_PER_STAGE = 5;
    localparam int BL_STAGES    = 6;
    localparam int NUM_STAGES   = CHR_STAGES + SQ_STAGES + BL_STAGES;

    // widths
    localparam int DC_W   = 26;  // chroma difference, signed
    localparam int SQ_W   = 49;  // one squared chroma term
    localparam int D2_W   = 50;  // squared distance
    localparam int ROOT_W = 25;  // distance in units of 2^-16
    localparam int REM_W  = 28;  // square root remainder
    localparam int DIV_W  = 21;  // blend dividend

    // chroma coefficients, scaled by 2^16
    localparam logic signed [17:0] CB_R = 18'sd6548;
    localparam logic signed [17:0] CB_G = 18'sd22026;
    localparam logic signed [17:0] CB_B = 18'sd28574;
    localparam logic signed [17:0] CR_R = 18'sd40305;
    localparam logic signed [17:0] CR_G = 18'sd36609;
    localparam logic signed [17:0] CR_B = 18'sd3696;

    // configuration register indexes
    localparam logic [2:0] CFG_KEY_RED   = 3'd0;
    localparam logic [2:0] CFG_KEY_GREEN = 3'd1;
    localparam logic [2:0] CFG_KEY_BLUE  = 3'd2;
    localparam logic [2:0] CFG_INNER     = 3'd3;
    localparam logic [2:0] CFG_OUTER     = 3'd4;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       last;
    } pix_t;

    typedef struct packed {
        logic [7:0]  key_red;
        logic [7:0]  key_green;
        logic [7:0]  key_blue;
        logic [11:0] inner;
        logic [11:0] outer;
    } cfg_t;

    typedef struct packed {
        logic [D2_W-1:0]   rad;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [DIV_W-1:0] rem;
        logic [7:0]       quo;
    } div_t;

    // one digit of the restoring square root
    function automatic sq_t sqrt_step(input sq_t x);
        sq_t y;
        logic [REM_W-1:0] cur;
        logic [REM_W-1:0] trial;
        cur = {x.rem[REM_W-3:0], x.rad[D2_W-1 -: 2]};
        trial = {1'b0, x.root, 2'b01};
        y.rad = {x.rad[D2_W-3:0], 2'b00};
        if (cur >= trial)
        begin
            y.rem  = cur - trial;
            y.root = {x.root[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            y.rem  = cur;
            y.root = {x.root[ROOT_W-2:0], 1'b0};
        end
        return y;
    endfunction

    // one quotient bit of the restoring division
    function automatic div_t div_step(input div_t x, input logic [11:0] d, input logic [2:0] k);
        div_t y;
        logic [DIV_W-1:0] sh;
        sh = {{(DIV_W-12){1'b0}}, d} << k;
        if (x.rem >= sh)
        begin
            y.rem = x.rem - sh;
            y.quo = {x.quo[6:0], 1'b1};
        end
        else
        begin
            y.rem = x.rem;
            y.quo = {x.quo[6:0], 1'b0};
        end
        return y;
    endfunction

endpackage

>>> design/ckp_chroma.sv
// chroma difference, squares and squared distance, three pipeline stages
// depends on ckp_pkg
module ckp_chroma
    import ckp_pkg::*;
(
    input  logic                  clk,
    input  logic [CHR_STAGES-1:0] adv,
    input  cfg_t                  cfg,
    input  pix_t                  pix_in,
    output logic [D2_W-1:0]       d2,
    output pix_t                  pix_out
);

    logic signed [8:0]      dr, dg, db;
    logic signed [DC_W-1:0] cb_next, cr_next;
    logic signed [DC_W-1:0] cb_reg, cr_reg;
    logic signed [51:0]     cb_sq, cr_sq;
    logic [SQ_W-1:0]        cb_sq_reg, cr_sq_reg;
    logic [D2_W-1:0]        d2_reg;
    pix_t                   pix0_reg, pix1_reg, pix2_reg;

    // key minus pixel, projected onto cb and cr
    always_comb
    begin
        dr = $signed({1'b0, cfg.key_red})   - $signed({1'b0, pix_in.red});
        dg = $signed({1'b0, cfg.key_green}) - $signed({1'b0, pix_in.green});
        db = $signed({1'b0, cfg.key_blue})  - $signed({1'b0, pix_in.blue});
        cb_next = DC_W'(27'sd0 - CB_R * dr - CB_G * dg + CB_B * db);
        cr_next = DC_W'(27'sd0 + CR_R * dr - CR_G * dg - CR_B * db);
    end

    always_comb
    begin
        cb_sq = cb_reg * cb_reg;
        cr_sq = cr_reg * cr_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            cb_reg   <= cb_next;
            cr_reg   <= cr_next;
            pix0_reg <= pix_in;
        end
        if (adv[1])
        begin
            cb_sq_reg <= cb_sq[SQ_W-1:0];
            cr_sq_reg <= cr_sq[SQ_W-1:0];
            pix1_reg  <= pix0_reg;
        end
        if (adv[2])
        begin
            d2_reg   <= {1'b0, cb_sq_reg} + {1'b0, cr_sq_reg};
            pix2_reg <= pix1_reg;
        end
    end

    assign d2      = d2_reg;
    assign pix_out = pix2_reg;

endmodule

>>> design/ckp_sqrt.sv
// pipelined integer square root of the squared chroma distance
// depends on ckp_pkg; five digits per stage
module ckp_sqrt
    import ckp_pkg::*;
(
    input  logic                 clk,
    input  logic [SQ_STAGES-1:0] adv,
    input  logic [D2_W-1:0]      d2,
    input  pix_t                 pix_in,
    output logic [ROOT_W-1:0]    root,
    output pix_t                 pix_out
);

    sq_t  sq_reg  [SQ_STAGES];
    pix_t pix_reg [SQ_STAGES];

    for (genvar g = 0; g < SQ_STAGES; g++)
    begin : g_stage
        sq_t  x_in;
        sq_t  sq_next;
        pix_t p_in;

        if (g == 0)
        begin : g_first
            assign x_in = '{rad: d2, rem: '0, root: '0};
            assign p_in = pix_in;
        end
        else
        begin : g_rest
            assign x_in = sq_reg[g-1];
            assign p_in = pix_reg[g-1];
        end

        // SQ_PER_STAGE digits of the root per stage
        always_comb
        begin
            sq_next = x_in;
            for (int k = 0; k < SQ_PER_STAGE; k++)
                sq_next = sqrt_step(sq_next);
        end

        always_ff @(posedge clk)
        begin
            if (adv[g])
            begin
                sq_reg[g]  <= sq_next;
                pix_reg[g] <= p_in;
            end
        end
    end

    assign root    = sq_reg[SQ_STAGES-1].root;
    assign pix_out = pix_reg[SQ_STAGES-1];

endmodule

>>> design/ckp_blend.sv
// region select, blend products, division by band width and output mux
// depends on ckp_pkg; six pipeline stages, the last is the output register
module ckp_blend
    import ckp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [BL_STAGES-1:0] adv,
    input  logic [BL_STAGES-1:0] valid,
    input  cfg_t                 cfg,
    input  logic [ROOT_W-1:0]    root,
    input  pix_t                 pix_in,
    output pix_t                 pix_out
);

    localparam logic [1:0] REGION_KEY  = 2'd0;
    localparam logic [1:0] REGION_BAND = 2'd1;
    localparam logic [1:0] REGION_PASS = 2'd2;

    logic [23:0]      ri, ro;
    logic [1:0]       region_next;
    logic [1:0]       region0_reg, region1_reg, region2_reg, region3_reg, region4_reg;
    logic [23:0]      n0_reg;
    logic [11:0]      d0_reg, d1_reg, d2_reg, d3_reg;
    pix_t             pix0_reg, pix1_reg, pix2_reg, pix3_reg, pix4_reg, pix5_reg;
    logic [11:0]      dn;
    logic [7:0]       chan [3];
    logic [7:0]       key  [3];
    logic [19:0]      cd_reg [3];
    logic [19:0]      kd_reg [3];
    logic [19:0]      nk_reg [3];
    logic [31:0]      na_reg;
    logic signed [21:0] y [3];
    logic [DIV_W-1:0] dvd_next [4];
    logic [DIV_W-1:0] dvd_reg  [4];
    div_t             div_a_next [4];
    div_t             div_b_next [4];
    div_t             div_a_reg  [4];
    div_t             div_b_reg  [4];
    logic [7:0]       keyed [3];
    pix_t             out_next;

    // which side of the radii the distance falls on
    always_comb
    begin
        ri = {cfg.inner, 12'b0};
        ro = {cfg.outer, 12'b0};
        if (root < {1'b0, ri})
            region_next = REGION_KEY;
        else if (root < {1'b0, ro})
            region_next = REGION_BAND;
        else
            region_next = REGION_PASS;
    end

    // channel views of the pixel and key
    always_comb
    begin
        chan[0] = pix0_reg.red;
        chan[1] = pix0_reg.green;
        chan[2] = pix0_reg.blue;
        key[0]  = cfg.key_red;
        key[1]  = cfg.key_green;
        key[2]  = cfg.key_blue;
        dn      = d0_reg - n0_reg[23:12];
    end

    // blend numerators with the low radius bits folded in, then clamp
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            y[c] = $signed({2'b0, cd_reg[c]}) - $signed({2'b0, kd_reg[c]})
                 + $signed({14'b0, nk_reg[c][19:12]});
            dvd_next[c] = (y[c] > 22'sd0) ? DIV_W'(y[c]) : '0;
        end
        dvd_next[3] = {1'b0, na_reg[31:12]};
    end

    // quotient by band width, upper and lower four bits
    always_comb
    begin
        for (int c = 0; c < 4; c++)
        begin
            div_a_next[c] = '{rem: dvd_reg[c], quo: '0};
            for (int j = 0; j < 4; j++)
                div_a_next[c] = div_step(div_a_next[c], d2_reg, 3'(7 - j));
            div_b_next[c] = div_a_reg[c];
            for (int j = 0; j < 4; j++)
                div_b_next[c] = div_step(div_b_next[c], d3_reg, 3'(3 - j));
        end
    end

    // output select per region
    always_comb
    begin
        keyed[0] = (pix4_reg.red   > cfg.key_red)   ? pix4_reg.red   - cfg.key_red   : 8'd0;
        keyed[1] = (pix4_reg.green > cfg.key_green) ? pix4_reg.green - cfg.key_green : 8'd0;
        keyed[2] = (pix4_reg.blue  > cfg.key_blue)  ? pix4_reg.blue  - cfg.key_blue  : 8'd0;
        out_next = pix4_reg;
        case (region4_reg)
            REGION_KEY:
            begin
                out_next.red   = keyed[0];
                out_next.green = keyed[1];
                out_next.blue  = keyed[2];
                out_next.alpha = 8'd0;
            end
            REGION_BAND:
            begin
                out_next.red   = div_b_reg[0].quo;
                out_next.green = div_b_reg[1].quo;
                out_next.blue  = div_b_reg[2].quo;
                out_next.alpha = div_b_reg[3].quo;
            end
            default:
            begin
                out_next = pix4_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            region0_reg <= region_next;
            n0_reg      <= 24'(root - {1'b0, ri});
            d0_reg      <= cfg.outer - cfg.inner;
            pix0_reg    <= pix_in;
        end
        if (adv[1])
        begin
            for (int c = 0; c < 3; c++)
            begin
                cd_reg[c] <= 20'(chan[c]) * 20'(d0_reg);
                kd_reg[c] <= 20'(dn) * 20'(key[c]);
                nk_reg[c] <= 20'(n0_reg[11:0]) * 20'(key[c]);
            end
            na_reg      <= 32'(n0_reg) * 32'(pix0_reg.alpha);
            region1_reg <= region0_reg;
            d1_reg      <= d0_reg;
            pix1_reg    <= pix0_reg;
        end
        if (adv[2])
        begin
            dvd_reg     <= dvd_next;
            region2_reg <= region1_reg;
            d2_reg      <= d1_reg;
            pix2_reg    <= pix1_reg;
        end
        if (adv[3])
        begin
            div_a_reg   <= div_a_next;
            region3_reg <= region2_reg;
            d3_reg      <= d2_reg;
            pix3_reg    <= pix2_reg;
        end
        if (adv[4])
        begin
            div_b_reg   <= div_b_next;
            region4_reg <= region3_reg;
            pix4_reg    <= pix3_reg;
        end
        if (adv[5])
        begin
            pix5_reg <= out_next;
        end
    end

    assign pix_out = pix5_reg;

    // the blend band exists only when outer is above inner
    a_band_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        valid[0] && region0_reg == REGION_BAND |-> d0_reg != 12'd0 && cfg.outer > cfg.inner)
        else $error("blend region with empty band");

    // band offset stays below the band width
    a_band_offset: assert property (@(posedge clk) disable iff (!rst_n)
        valid[0] && region0_reg == REGION_BAND |-> n0_reg[23:12] < d0_reg)
        else $error("band offset beyond band width");

endmodule

>>> design/chroma_key_pixel_top.sv
// chroma key soft matte, top level: stream ports, config registers, stage valids
// depends on ckp_pkg, ckp_chroma, ckp_sqrt, ckp_blend
// 14 register stages between the input port and the output port
// throughput: one pixel per cycle; each stage holds only while the one after it is full
// the square root takes five stages at five digits each; the band division two stages
// reset (rst_n low, asynchronous) empties the pipeline and loads the default key registers
module chroma_key_pixel_top
    import ckp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // pixel_red, pixel_green, pixel_blue, pixel_alpha
    input  logic        s_axis_tlast,   // frame_end_in
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // out_red, out_green, out_blue, out_alpha
    output logic        m_axis_tlast,   // frame_end_out
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_data
);

    cfg_t                  cfg_reg;
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] adv;
    pix_t                  pix_in, pix_chr, pix_sq, pix_out;
    logic [D2_W-1:0]       d2;
    logic [ROOT_W-1:0]     root;

    // a stage moves when it is empty or the next one moves
    always_comb
    begin
        adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || m_axis_tready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
            adv[i] = !valid_reg[i] || adv[i+1];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else
        begin
            if (adv[0])
                valid_reg[0] <= s_axis_tvalid;
            for (int i = 1; i < NUM_STAGES; i++)
                if (adv[i])
                    valid_reg[i] <= valid_reg[i-1];
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.key_red   <= 8'd0;
            cfg_reg.key_green <= 8'd255;
            cfg_reg.key_blue  <= 8'd0;
            cfg_reg.inner     <= 12'd216;
            cfg_reg.outer     <= 12'd288;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_KEY_RED:   cfg_reg.key_red   <= cfg_data[7:0];
                CFG_KEY_GREEN: cfg_reg.key_green <= cfg_data[7:0];
                CFG_KEY_BLUE:  cfg_reg.key_blue  <= cfg_data[7:0];
                CFG_INNER:     cfg_reg.inner     <= cfg_data;
                CFG_OUTER:     cfg_reg.outer     <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // unpack the input item
    always_comb
    begin
        pix_in.red   = s_axis_tdata[7:0];
        pix_in.green = s_axis_tdata[15:8];
        pix_in.blue  = s_axis_tdata[23:16];
        pix_in.alpha = s_axis_tdata[31:24];
        pix_in.last  = s_axis_tlast;
    end

    ckp_chroma u_chroma (
        .clk     (clk),
        .adv     (adv[CHR_STAGES-1:0]),
        .cfg     (cfg_reg),
        .pix_in  (pix_in),
        .d2      (d2),
        .pix_out (pix_chr)
    );

    ckp_sqrt u_sqrt (
        .clk     (clk),
        .adv     (adv[CHR_STAGES+SQ_STAGES-1:CHR_STAGES]),
        .d2      (d2),
        .pix_in  (pix_chr),
        .root    (root),
        .pix_out (pix_sq)
    );

    ckp_blend u_blend (
        .clk     (clk),
        .rst_n   (rst_n),
        .adv     (adv[NUM_STAGES-1:CHR_STAGES+SQ_STAGES]),
        .valid   (valid_reg[NUM_STAGES-1:CHR_STAGES+SQ_STAGES]),
        .cfg     (cfg_reg),
        .root    (root),
        .pix_in  (pix_sq),
        .pix_out (pix_out)
    );

    assign s_axis_tready = adv[0];
    assign m_axis_tvalid = valid_reg[NUM_STAGES-1];
    assign m_axis_tdata  = {pix_out.alpha, pix_out.blue, pix_out.green, pix_out.red};
    assign m_axis_tlast  = pix_out.last;

    // input backs up only behind a full, stalled pipeline
    a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (&valid_reg) && !m_axis_tready)
        else $error("input stalled with room in the pipeline");

    // an accepted item lands in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> valid_reg[0])
        else $error("accepted item lost at pipeline entry");

    // a waiting output item holds still until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast))
        else $error("output item changed while stalled");

endmodule

>>> sim/tb_chroma_key_pixel_top.sv
// self-checking bench for chroma_key_pixel_top: directed table, a hard-edge case, then random pixels
// depends on ckp_pkg and chroma_key_pixel_top; predicts each output pixel in-bench
module tb_chroma_key_pixel_top;
    import ckp_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // red, green, blue, alpha
    logic        s_axis_tlast;   // frame end
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // red, green, blue, alpha
    logic        m_axis_tlast;   // frame end
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_data;

    typedef struct {
        logic [31:0] data;
        logic        last;
    } matte_pix_t;

    typedef struct {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic [7:0] a;
        logic       last;
        bit         typed;      // expected output given in the row
        logic [31:0] exp_data;
    } pix_row_t;

    matte_pix_t  matte_q[$];
    int          errors;
    int          quiet_cycles;
    bit          sink_free;     // receiver may stall at random
    bit          hold_sink;     // long receiver hold-off
    int          hold_len;
    logic [7:0]  k_red, k_green, k_blue;
    logic [11:0] r_inner, r_outer;
    pix_row_t    rows[$];

    chroma_key_pixel_top dut (.*);

    always #5 clk = ~clk;

    // chroma distance, floor of sqrt in units of 2^-16
    function automatic longint unsigned chroma_dist(logic [7:0] r, logic [7:0] g,
                                                    logic [7:0] b);
        longint dr, dg, db, dcb, dcr;
        longint unsigned d2, res, bt;
        dr = longint'(k_red) - longint'(r);
        dg = longint'(k_green) - longint'(g);
        db = longint'(k_blue) - longint'(b);
        dcb = -6548 * dr - 22026 * dg + 28574 * db;
        dcr = 40305 * dr - 36609 * dg - 3696 * db;
        d2 = dcb * dcb + dcr * dcr;
        res = 0;
        bt = 64'd1 << 62;
        while (bt > d2)
            bt >>= 2;
        while (bt != 0)
        begin
            if (d2 >= res + bt)
            begin
                d2 -= res + bt;
                res = (res >> 1) + bt;
            end
            else
                res >>= 1;
            bt >>= 2;
        end
        return res;
    endfunction

    function automatic logic [7:0] band_chan(logic [7:0] c, logic [7:0] k,
                                             longint unsigned n, longint unsigned d);
        longint unsigned pos, neg;
        pos = c * d;
        neg = (d - n) * k;
        if (pos <= neg)
            return 8'd0;
        return 8'((pos - neg) / d);
    endfunction

    // expected matte pixel for the current key settings
    function automatic logic [31:0] predict_matte(logic [7:0] r, logic [7:0] g,
                                                  logic [7:0] b, logic [7:0] a);
        longint unsigned s, ri, ro, n, d;
        s = chroma_dist(r, g, b);
        ri = longint'(r_inner) << 12;
        ro = longint'(r_outer) << 12;
        if (s < ri)
            return {8'd0, (b > k_blue) ? b - k_blue : 8'd0,
                    (g > k_green) ? g - k_green : 8'd0, (r > k_red) ? r - k_red : 8'd0};
        if (s < ro)
        begin
            n = s - ri;
            d = ro - ri;
            return {8'((n * a) / d), band_chan(b, k_blue, n, d),
                    band_chan(g, k_green, n, d), band_chan(r, k_red, n, d)};
        end
        return {a, b, g, r};
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("mismatch %s: got %h expected %h", what, got, want);
        errors++;
    endtask

    // output check and receiver stalls
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (matte_q.size() == 0)
                report_mismatch("unexpected item", m_axis_tdata, 0);
            else
            begin
                if (m_axis_tdata[7:0] !== matte_q[0].data[7:0])
                    report_mismatch("red", m_axis_tdata[7:0], matte_q[0].data[7:0]);
                if (m_axis_tdata[15:8] !== matte_q[0].data[15:8])
                    report_mismatch("green", m_axis_tdata[15:8], matte_q[0].data[15:8]);
                if (m_axis_tdata[23:16] !== matte_q[0].data[23:16])
                    report_mismatch("blue", m_axis_tdata[23:16], matte_q[0].data[23:16]);
                if (m_axis_tdata[31:24] !== matte_q[0].data[31:24])
                    report_mismatch("alpha", m_axis_tdata[31:24], matte_q[0].data[31:24]);
                if (m_axis_tlast !== matte_q[0].last)
                    report_mismatch("frame end", m_axis_tlast, matte_q[0].last);
                void'(matte_q.pop_front());
            end
        end
        if (hold_sink)
        begin
            m_axis_tready <= 1'b0;
            hold_len <= hold_len + 1;
        end
        else if (!sink_free)
            m_axis_tready <= 1'b1;
        else if (hold_len > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_len <= hold_len - 1;
        end
        else if ($urandom_range(0, 7) == 0)
        begin
            m_axis_tready <= 1'b0;
            hold_len <= $urandom_range(0, 9);
        end
        else
            m_axis_tready <= 1'b1;
    end

    // watchdog on cycles without any handshake, outside a receiver hold-off
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready) || hold_sink)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > 2000)
        begin
            $display("chroma_key_pixel_top regression: fail");
            $finish;
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_KEY_RED:   k_red = val[7:0];
            CFG_KEY_GREEN: k_green = val[7:0];
            CFG_KEY_BLUE:  k_blue = val[7:0];
            CFG_INNER:     r_inner = val;
            CFG_OUTER:     r_outer = val;
            default: ;
        endcase
    endtask

    task automatic set_key(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                           logic [11:0] ri, logic [11:0] ro);
        write_reg(CFG_KEY_RED, r);
        write_reg(CFG_KEY_GREEN, g);
        write_reg(CFG_KEY_BLUE, b);
        write_reg(CFG_INNER, ri);
        write_reg(CFG_OUTER, ro);
    endtask

    task automatic drain();
        while (matte_q.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // offer one pixel, with an optional random gap first
    task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                              logic [7:0] a, logic last, bit gaps);
        matte_pix_t m;
        if (gaps && $urandom_range(0, 5) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {a, b, g, r};
        s_axis_tlast  <= last;
        m.data = predict_matte(r, g, b, a);
        m.last = last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        matte_q = {matte_q, m};
    endtask

    task automatic random_pixels(int count, bit gaps);
        logic [7:0] r, g, b;
        for (int i = 0; i < count; i++)
        begin
            // most pixels sit near the key so the band and keyed cases are hit
            if ($urandom_range(0, 2) != 0)
            begin
                r = 8'(int'(k_red) + $urandom_range(0, 40) - 20);
                g = 8'(int'(k_green) + $urandom_range(0, 40) - 20);
                b = 8'(int'(k_blue) + $urandom_range(0, 40) - 20);
            end
            else
            begin
                r = 8'($urandom);
                g = 8'($urandom);
                b = 8'($urandom);
            end
            send_pixel(r, g, b, 8'($urandom), $urandom_range(0, 15) == 0, gaps);
        end
        s_axis_tvalid <= 1'b0;
    endtask

    function automatic pix_row_t row(logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                     logic [7:0] a, logic last, bit typed,
                                     logic [31:0] exp_data);
        pix_row_t x;
        x = '{r, g, b, a, last, typed, exp_data};
        return x;
    endfunction

    initial
    begin
        clk = 0;
        rst_n = 0;
        s_axis_tvalid = 0;
        s_axis_tdata = 0;
        s_axis_tlast = 0;
        m_axis_tready = 0;
        cfg_valid = 0;
        cfg_index = 0;
        cfg_data = 0;
        errors = 0;
        quiet_cycles = 0;
        sink_free = 0;
        hold_sink = 0;
        hold_len = 0;
        k_red = 0;
        k_green = 255;
        k_blue = 0;
        r_inner = 216;
        r_outer = 288;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table at reset key: exact key, black, white, band, frame end
        rows = {rows, row(0, 255, 0, 255, 0, 1, 32'h00000000)};
        rows = {rows, row(0, 255, 0, 0, 1, 1, 32'h00000000)};
        rows = {rows, row(255, 255, 255, 255, 0, 1, 32'hFFFFFFFF)};
        rows = {rows, row(0, 0, 0, 128, 1, 1, 32'h80000000)};
        rows = {rows, row(255, 0, 255, 77, 0, 1, 32'h4DFF00FF)};
        rows = {rows, row(10, 230, 12, 200, 0, 0, 0)};
        rows = {rows, row(30, 220, 40, 255, 0, 0, 0)};
        rows = {rows, row(40, 200, 50, 255, 1, 0, 0)};
        rows = {rows, row(60, 190, 60, 170, 0, 0, 0)};
        rows = {rows, row(20, 240, 20, 1, 0, 0, 0)};
        rows = {rows, row(85, 170, 51, 254, 0, 0, 0)};
        rows = {rows, row(170, 85, 204, 127, 1, 0, 0)};
        foreach (rows[i])
        begin
            send_pixel(rows[i].r, rows[i].g, rows[i].b, rows[i].a, rows[i].last, 0);
            if (rows[i].typed && matte_q[$].data !== rows[i].exp_data)
                report_mismatch("table", matte_q[$].data, rows[i].exp_data);
        end
        s_axis_tvalid <= 1'b0;
        drain();

        // hard edge: outer not above inner, and the out-of-range index is ignored
        set_key(255, 0, 255, 100, 100);
        write_reg(3'd7, 12'hFFF);
        send_pixel(255, 0, 255, 9, 1, 0);
        send_pixel(250, 10, 240, 9, 0, 0);
        send_pixel(0, 255, 0, 9, 0, 0);
        s_axis_tvalid <= 1'b0;
        drain();

        // random phases under several settings, extremes included
        sink_free = 1;
        random_pixels(120, 1);
        drain();
        set_key(0, 0, 255, 0, 4095);
        random_pixels(100, 1);
        // pause until all results are back
        drain();
        set_key(255, 255, 255, 4095, 0);
        random_pixels(60, 1);
        drain();
        set_key(128, 64, 200, 150, 600);
        // receiver holds off while the sender keeps offering
        hold_sink = 1;
        fork
            random_pixels(100, 0);
            begin
                repeat (60) @(posedge clk);
                hold_sink = 0;
            end
        join
        drain();
        set_key(30, 180, 90, 40, 700);
        random_pixels(140, 1);
        // last part: no idling on either side
        sink_free = 0;
        random_pixels(120, 0);
        drain();

        if (errors == 0)
            $display("chroma_key_pixel_top regression: pass");
        else
            $display("chroma_key_pixel_top regression: fail");
        $finish;
    end
endmodule
